// ----- hdl/c2s_pkg.sv -----
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants for the cartesian to spherical converter
// Working word formats, the arctangent table and the output limits.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

	localparam int CORDIC_STAGES = 28;
	localparam int COORD_WIDTH   = 32;
	localparam int WORK_W        = 64;
	localparam int ANG_FRAC      = 58;
	localparam int LIFT          = ANG_FRAC - COORD_WIDTH;
	localparam int OUT_SHIFT     = ANG_FRAC - 29;
	localparam int LON_W         = 32;
	localparam int LAT_W         = 31;
	localparam int GAIN_FRAC     = 30;
	localparam int GAIN_HI_W     = 30;

	localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q30   = 30'd652032875;
	localparam logic [LON_W-1:0]     LON_TWO_PI_Q29 = 32'd3373259426;
	localparam logic [LAT_W-1:0]     LAT_LIMIT      = 31'd843314856;

	typedef logic signed [WORK_W-1:0] work_t;

	typedef struct packed {
		work_t             z;
		logic [LON_W-1:0]  lon;
		logic              hz;
		logic              zv;
	} c2s_side_t;

	localparam work_t ROUND_Q58 = work_t'(64'd1 << (ANG_FRAC - 30));

	// restoring division, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/m) in Q58 by the alternating series
	function automatic work_t atan_inv(input logic [63:0] m);
		logic [63:0] p;
		logic [63:0] mm;
		logic [63:0] k;
		logic [63:0] t;
		work_t       sum;
		p   = udiv(64'd1 << ANG_FRAC, m);
		mm  = m * m;
		k   = '0;
		sum = '0;
		while (p != 64'd0) begin
			t = udiv(p, (k << 1) + 64'd1);
			if (k[0])
				sum = sum - work_t'(t);
			else
				sum = sum + work_t'(t);
			p = udiv(p, mm);
			k = k + 64'd1;
		end
		return sum;
	endfunction

	localparam work_t QUARTER_PI_Q58 = (atan_inv(64'd5) <<< 2) - atan_inv(64'd239);
	localparam work_t PI_Q58         = QUARTER_PI_Q58 <<< 2;
	localparam work_t TWO_PI_Q58     = QUARTER_PI_Q58 <<< 3;

	function automatic work_t atan_q58(input int i);
		if (i == 0)
			return QUARTER_PI_Q58;
		return atan_inv(64'd1 << i);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/cartesian_to_spherical.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_spherical: point to longitude / latitude converter
// Two pipelined CORDIC vectoring chains: atan2(y, x) folded to [0, 2pi),
// then atan2(z, |xy|) after the inverse gain scaling.
//
//   channel   words           handshake
//   point     x/y/z_coord     start (busy is always low)
//   angles    longitude,      done, one cycle per word
//             latitude,
//             zero_vector
//
// A word is taken every cycle; its result is registered through the two
// 28-stage rotation chains, the fold and gain stages and the output register.
// Reset clears every valid bit, so no word is delivered for points in flight
// at reset. The receiver cannot stall and the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [31:0]            x_coord,
	input  logic signed [31:0]            y_coord,
	input  logic signed [31:0]            z_coord,
	output logic                          done,
	output logic [c2s_pkg::LON_W-1:0]     longitude,
	output logic signed [c2s_pkg::LAT_W-1:0] latitude,
	output logic                          zero_vector
);
	import c2s_pkg::*;

	localparam int LATENCY = 2 * CORDIC_STAGES + 4;

	// lift and fold into the right half plane
	work_t     xw, yw, zw;
	logic      zv_in, hz_in;

	logic      v_s1;
	work_t     x_s1, y_s1, a_s1;
	c2s_side_t side_s1;

	logic      c1_valid;
	work_t     c1_x, c1_y, c1_a;
	c2s_side_t c1_side;

	work_t                       u_mag;
	logic                        v_s2;
	work_t                       afix_s2;
	logic [2*GAIN_FRAC-1:0]      phi_s2;
	logic [2*GAIN_FRAC-1:0]      plo_s2;
	c2s_side_t                   side_s2;

	work_t             lon_sum;
	logic [LON_W-1:0]  lon_raw;
	logic              v_s3;
	work_t             r_s3;
	c2s_side_t         side_s3;

	logic      c2_valid;
	work_t     c2_x, c2_y, c2_a;
	c2s_side_t c2_side;

	work_t     lat_full;
	work_t     lat_clamp;

	assign busy = 1'b0;

	assign xw = work_t'($signed(x_coord[COORD_WIDTH-1:0])) <<< LIFT;
	assign yw = work_t'($signed(y_coord[COORD_WIDTH-1:0])) <<< LIFT;
	assign zw = work_t'($signed(z_coord[COORD_WIDTH-1:0])) <<< LIFT;
	assign hz_in = (x_coord[COORD_WIDTH-1:0] == '0) && (y_coord[COORD_WIDTH-1:0] == '0);
	assign zv_in = hz_in && (z_coord[COORD_WIDTH-1:0] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		side_s1.z   <= zw;
		side_s1.lon <= '0;
		side_s1.hz  <= hz_in;
		side_s1.zv  <= zv_in;
		if (xw[WORK_W-1]) begin
			x_s1 <= -xw;
			y_s1 <= -yw;
			a_s1 <= PI_Q58;
		end else begin
			x_s1 <= xw;
			y_s1 <= yw;
			a_s1 <= '0;
		end
	end

	c2s_vector_chain u_lon_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_x      (x_s1),
		.in_y      (y_s1),
		.in_a      (a_s1),
		.in_side   (side_s1),
		.out_valid (c1_valid),
		.out_x     (c1_x),
		.out_y     (c1_y),
		.out_a     (c1_a),
		.out_side  (c1_side)
	);

	// wrap negative angle, split the gain multiply
	assign u_mag = (c1_side.hz || c1_x[WORK_W-1]) ? '0 : c1_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= c1_valid;
	end

	always_ff @(posedge clk) begin
		side_s2 <= c1_side;
		afix_s2 <= c1_a[WORK_W-1] ? c1_a + TWO_PI_Q58 : c1_a;
		phi_s2  <= (2*GAIN_FRAC)'(u_mag[GAIN_FRAC +: GAIN_HI_W])
			* (2*GAIN_FRAC)'(INV_GAIN_Q30);
		plo_s2  <= (2*GAIN_FRAC)'(u_mag[GAIN_FRAC-1:0])
			* (2*GAIN_FRAC)'(INV_GAIN_Q30);
	end

	// round longitude, sum the partial products
	assign lon_sum = afix_s2 + ROUND_Q58;
	assign lon_raw = lon_sum[OUT_SHIFT +: LON_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		side_s3.z  <= side_s2.z;
		side_s3.hz <= side_s2.hz;
		side_s3.zv <= side_s2.zv;
		if (side_s2.hz || lon_raw >= LON_TWO_PI_Q29)
			side_s3.lon <= '0;
		else
			side_s3.lon <= lon_raw;
		r_s3 <= work_t'({1'b0, phi_s2}) + work_t'({1'b0, plo_s2[2*GAIN_FRAC-1:GAIN_FRAC]});
	end

	c2s_vector_chain u_lat_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_x      (r_s3),
		.in_y      (side_s3.z),
		.in_a      ('0),
		.in_side   (side_s3),
		.out_valid (c2_valid),
		.out_x     (c2_x),
		.out_y     (c2_y),
		.out_a     (c2_a),
		.out_side  (c2_side)
	);

	// round and clamp latitude
	assign lat_full = (c2_a + ROUND_Q58) >>> OUT_SHIFT;

	always_comb begin
		lat_clamp = lat_full;
		if (lat_full > work_t'({1'b0, LAT_LIMIT}))
			lat_clamp = work_t'({1'b0, LAT_LIMIT});
		else if (lat_full < -work_t'({1'b0, LAT_LIMIT}))
			lat_clamp = -work_t'({1'b0, LAT_LIMIT});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= c2_valid;
	end

	always_ff @(posedge clk) begin
		zero_vector <= c2_side.zv;
		longitude   <= c2_side.zv ? '0 : c2_side.lon;
		latitude    <= c2_side.zv ? '0 : lat_clamp[LAT_W-1:0];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word lost in pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without accepted word");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_vector |-> longitude == '0 && latitude == '0)
		else $error("zero vector with nonzero angles");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> longitude < LON_TWO_PI_Q29)
		else $error("longitude not wrapped");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $signed(latitude) <= $signed(LAT_LIMIT)
			&& $signed(latitude) >= -$signed(LAT_LIMIT))
		else $error("latitude beyond clamp");

	logic unused_ok;
	assign unused_ok = ^{c1_y, c2_x, c2_y, c2_side.z, c2_side.hz};

endmodule

`default_nettype wire

// ----- hdl/c2s_vector_chain.sv -----
// ----------------------------------------------------------------------------
// c2s_vector_chain: pipelined CORDIC vectoring chain
// One micro-rotation per register stage; drives y to zero, sums the angle
// and carries a side word alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_vector_chain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  c2s_pkg::work_t    in_x,
	input  c2s_pkg::work_t    in_y,
	input  c2s_pkg::work_t    in_a,
	input  c2s_pkg::c2s_side_t in_side,
	output logic              out_valid,
	output c2s_pkg::work_t    out_x,
	output c2s_pkg::work_t    out_y,
	output c2s_pkg::work_t    out_a,
	output c2s_pkg::c2s_side_t out_side
);
	import c2s_pkg::*;

	logic      valid_s [0:CORDIC_STAGES];
	work_t     x_s     [0:CORDIC_STAGES];
	work_t     y_s     [0:CORDIC_STAGES];
	work_t     a_s     [0:CORDIC_STAGES];
	c2s_side_t side_s  [0:CORDIC_STAGES];

	assign valid_s[0] = in_valid;
	assign x_s[0]     = in_x;
	assign y_s[0]     = in_y;
	assign a_s[0]     = in_a;
	assign side_s[0]  = in_side;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam work_t ATAN_I = atan_q58(i);
		work_t dx;
		work_t dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[i+1] <= 1'b0;
			else
				valid_s[i+1] <= valid_s[i];
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (!y_s[i][WORK_W-1]) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				a_s[i+1] <= a_s[i] + ATAN_I;
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				a_s[i+1] <= a_s[i] - ATAN_I;
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STAGES];
	assign out_x     = x_s[CORDIC_STAGES];
	assign out_y     = y_s[CORDIC_STAGES];
	assign out_a     = a_s[CORDIC_STAGES];
	assign out_side  = side_s[CORDIC_STAGES];

endmodule

`default_nettype wire

// ----- sim/cartesian_to_spherical_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_tb: self-checking bench for the point converter
// Sends cartesian points through the start/busy handshake with random idle
// gaps, predicts longitude, latitude and the zero flag per point with a
// bit-true CORDIC model, and checks every done word against it in order.
// ----------------------------------------------------------------------------

module cartesian_to_spherical_tb;

	localparam int      NUM_STAGES   = 28;
	localparam int      LIFT_BITS    = 26;
	localparam int      FLUSH_CYCLES = 2 * NUM_STAGES + 14;
	localparam int      STALL_LIMIT  = 2000;
	localparam longint  HALF_LSB     = 64'sd268435456;
	localparam longint unsigned GAIN_Q30     = 64'd652032875;
	localparam longint unsigned GAIN_MASK    = (64'd1 << 30) - 64'd1;
	localparam longint unsigned LON_WRAP_Q29 = 64'd3373259426;
	localparam longint  LAT_CLAMP    = 64'sd843314856;
	localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;

	typedef struct packed {
		logic [31:0]        lon;
		logic signed [30:0] lat;
		logic               zv;
	} angles_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic signed [31:0]  x_coord;
	logic signed [31:0]  y_coord;
	logic signed [31:0]  z_coord;
	logic                done;
	logic [31:0]         longitude;
	logic signed [30:0]  latitude;
	logic                zero_vector;

	longint  atan_lut [0:NUM_STAGES-1];
	longint  pi_q58;
	angles_t pending_angles [$];
	int      fault_count     = 0;
	int      points_sent     = 0;
	int      results_checked = 0;
	int      zero_words      = 0;
	int      wrapped_words   = 0;
	int      stall_cycles    = 0;
	bit      no_idle         = 1'b0;

	cartesian_to_spherical u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.done        (done),
		.longitude   (longitude),
		.latitude    (latitude),
		.zero_vector (zero_vector)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// atan(1/m) in Q58 by alternating series
	function automatic longint series_atan(input longint unsigned m);
		longint unsigned p;
		longint unsigned mm;
		longint unsigned k;
		longint          t;
		longint          acc;
		p   = (64'd1 << 58) / m;
		mm  = m * m;
		k   = 0;
		acc = 0;
		while (p != 0) begin
			t = $signed(p / (2 * k + 1));
			if (k % 2 == 1)
				acc = acc - t;
			else
				acc = acc + t;
			p = p / mm;
			k = k + 1;
		end
		return acc;
	endfunction

	function automatic void build_atan_lut();
		longint quarter;
		quarter = 4 * series_atan(64'd5) - series_atan(64'd239);
		pi_q58 = 4 * quarter;
		atan_lut[0] = quarter;
		for (int i = 1; i < NUM_STAGES; i++)
			atan_lut[i] = series_atan(64'd1 << i);
	endfunction

	function automatic void vector_rotate(inout longint xv, inout longint yv,
			inout longint av);
		longint dx;
		longint dy;
		for (int i = 0; i < NUM_STAGES; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv >= 0) begin
				xv = xv + dx;
				yv = yv - dy;
				av = av + atan_lut[i];
			end else begin
				xv = xv - dx;
				yv = yv + dy;
				av = av - atan_lut[i];
			end
		end
	endfunction

	function automatic angles_t predict_angles(input logic signed [31:0] xc,
			input logic signed [31:0] yc, input logic signed [31:0] zc);
		longint          x;
		longint          y;
		longint          z;
		longint          r;
		longint          a;
		longint          b;
		longint          lat_w;
		longint unsigned u;
		longint unsigned lon_w;
		angles_t         res;
		res = '0;
		if (xc == 0 && yc == 0 && zc == 0) begin
			res.zv = 1'b1;
			return res;
		end
		x = longint'(xc) <<< LIFT_BITS;
		y = longint'(yc) <<< LIFT_BITS;
		z = longint'(zc) <<< LIFT_BITS;
		r = 0;
		lon_w = 0;
		if (x != 0 || y != 0) begin
			a = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				a = pi_q58;
			end
			vector_rotate(x, y, a);
			if (a < 0)
				a = a + 2 * pi_q58;
			lon_w = ($unsigned(a) + $unsigned(HALF_LSB)) >> 29;
			if (lon_w >= LON_WRAP_Q29)
				lon_w = 0;
			r = x;
		end
		u = (r > 0) ? $unsigned(r) : 64'd0;
		r = $signed((u >> 30) * GAIN_Q30 + (((u & GAIN_MASK) * GAIN_Q30) >> 30));
		b = 0;
		vector_rotate(r, z, b);
		lat_w = (b + HALF_LSB) >>> 29;
		if (lat_w > LAT_CLAMP)
			lat_w = LAT_CLAMP;
		if (lat_w < -LAT_CLAMP)
			lat_w = -LAT_CLAMP;
		res.lon = 32'(lon_w);
		res.lat = 31'(lat_w);
		return res;
	endfunction

	always @(posedge clk) begin : check_proc
		angles_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_angles.size() == 0) begin
					$error("result word with no point outstanding");
					fault_count++;
				end else begin
					want = pending_angles.pop_front();
					results_checked++;
					if (want.zv)
						zero_words++;
					if (longitude !== want.lon) begin
						$error("longitude: expected %0d, got %0d", want.lon, longitude);
						fault_count++;
					end
					if (latitude !== want.lat) begin
						$error("latitude: expected %0d, got %0d", want.lat, latitude);
						fault_count++;
					end
					if (zero_vector !== want.zv) begin
						$error("zero_vector: expected %0d, got %0d", want.zv, zero_vector);
						fault_count++;
					end
				end
			end
			if (start && !busy) begin
				want = predict_angles(x_coord, y_coord, z_coord);
				if (want.lon == 0 && (x_coord > 0) && (y_coord < 0))
					wrapped_words++;
				pending_angles.push_back(want);
				points_sent++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("FAIL cartesian_to_spherical");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4: begin
				v = $urandom_range(0, 255);
				if ($urandom_range(0, 1))
					v = -v;
			end
			5: v = 0;
			6: begin
				case ($urandom_range(0, 3))
					0: v = COORD_MIN;
					1: v = COORD_MAX;
					2: v = 1;
					default: v = -1;
				endcase
			end
			7: begin
				v = 32'sd1 <<< $urandom_range(0, 30);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = $signed($urandom) >>> $urandom_range(1, 30);
		endcase
		return v;
	endfunction

	task automatic send_point(input logic signed [31:0] xv, input logic signed [31:0] yv,
			input logic signed [31:0] zv);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start   <= 1'b1;
		x_coord <= xv;
		y_coord <= yv;
		z_coord <= zv;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MAX, 0);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX);
		send_point(COORD_MIN, 0, 0);
		send_point(0, COORD_MIN, 0);
		send_point(0, COORD_MAX, 0);
		send_point(COORD_MIN, 0, COORD_MIN);
		send_point(1, 0, 0);
		send_point(0, 1, 0);
		send_point(-1, -1, -1);
	endtask

	task automatic test_special_cases();
		// all-zero vector
		send_point(0, 0, 0);
		// horizontal zero
		send_point(0, 0, COORD_MAX);
		send_point(0, 0, COORD_MIN);
		send_point(0, 0, 1);
		send_point(0, 0, -1);
		// left half plane
		send_point(-1, 0, 0);
		send_point(-1, 1, 5);
		send_point(-1, -1, -5);
		// negative angle, and one that rounds up to a full turn
		send_point(1, -1, 0);
		send_point(COORD_MAX, -1, 0);
		// latitude close to the poles
		send_point(1, 0, COORD_MAX);
		send_point(-1, 1, COORD_MIN);
		send_point(0, 0, 0);
	endtask

	task automatic test_random_points(input int count);
		repeat (count) begin
			if ($urandom_range(0, 49) == 0)
				send_point(0, 0, 0);
			else
				send_point(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// one dominant axis, the others tiny: hits the wrap and the latitude clamp
	task automatic test_axis_points(input int count);
		logic signed [31:0] c [0:2];
		int                 axis;
		repeat (count) begin
			axis = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++) begin
				c[i] = $urandom_range(0, 3);
				if ($urandom_range(0, 1))
					c[i] = -c[i];
			end
			c[axis] = $urandom_range(32'h1000_0000, 32'h7fff_ffff);
			if ($urandom_range(0, 1))
				c[axis] = -c[axis];
			send_point(c[0], c[1], c[2]);
		end
	endtask

	task automatic test_back_to_back(input int count);
		no_idle = 1'b1;
		test_random_points(count);
		no_idle = 1'b0;
	endtask

	initial begin
		build_atan_lut();
		arst_n  = 1'b0;
		start   = 1'b0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_special_cases();
		drain_results();
		test_random_points(900);
		test_axis_points(300);
		drain_results();
		test_back_to_back(430);

		drain_results();
		repeat (FLUSH_CYCLES) @(posedge clk);
		$display("%0d points sent, %0d words checked (%0d zero vectors, %0d full-turn wraps)",
			points_sent, results_checked, zero_words, wrapped_words);
		$display("covered extremes, axes, all quadrants, idle gaps and back-to-back words");
		if (fault_count == 0 && pending_angles.size() == 0)
			$display("PASS cartesian_to_spherical");
		else
			$display("FAIL cartesian_to_spherical");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/c2s_pkg.sv
hdl/c2s_vector_chain.sv
hdl/cartesian_to_spherical.sv
sim/cartesian_to_spherical_tb.sv
